>>> rtl/fnut_pkg.sv
`timescale 1ns / 1ps

package fnut_pkg;

  // operator codes
  localparam logic [3:0] OP_PROP    = 4'd0;
  localparam logic [3:0] OP_TRUE    = 4'd1;
  localparam logic [3:0] OP_FALSE   = 4'd2;
  localparam logic [3:0] OP_NOT     = 4'd3;
  localparam logic [3:0] OP_NEXT    = 4'd4;
  localparam logic [3:0] OP_AND     = 4'd5;
  localparam logic [3:0] OP_OR      = 4'd6;
  localparam logic [3:0] OP_UNTIL   = 4'd7;
  localparam logic [3:0] OP_RELEASE = 4'd8;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_NOARG = 2'd2;

  localparam int unsigned NODE_W = 21;

  typedef struct packed {
    logic [3:0] op;
    logic [7:0] a0;
    logic [7:0] a1;
  } req_t;

  typedef struct packed {
    logic       pr;
    logic [7:0] a1;
    logic [7:0] a0;
    logic [3:0] op;
  } node_t;

  // number of node operands an operator refers to
  function automatic logic [1:0] arity(input logic [3:0] op);
    logic [1:0] n;
    n = 2'd0;
    if (op == OP_NOT || op == OP_NEXT) begin
      n = 2'd1;
    end else if (op == OP_AND || op == OP_OR || op == OP_UNTIL || op == OP_RELEASE) begin
      n = 2'd2;
    end
    return n;
  endfunction

endpackage

>>> rtl/fnut_if.sv
`timescale 1ns / 1ps

interface fnut_req_if;
  logic       valid;
  logic       ready;
  logic [3:0] opcode;
  logic [7:0] first_arg;
  logic [7:0] second_arg;

  modport source (output valid, output opcode, output first_arg, output second_arg,
                  input ready);
  modport sink (input valid, input opcode, input first_arg, input second_arg,
                output ready);
endinterface

interface fnut_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] node_index;
  logic       was_created;
  logic       is_propositional;
  logic [1:0] status;

  modport source (output valid, output node_index, output was_created,
                  output is_propositional, output status, input ready);
  modport sink (input valid, input node_index, input was_created,
                input is_propositional, input status, output ready);
endinterface

>>> rtl/fnut_ram.sv
`timescale 1ns / 1ps

module fnut_ram #(
  parameter int unsigned WIDTH = 21,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/fnut_match.sv
`timescale 1ns / 1ps

module fnut_match (
  input  fnut_pkg::node_t node_i,
  input  fnut_pkg::req_t  req_i,
  output logic            hit_o
);
  import fnut_pkg::*;

  // prop nodes ignore the second argument
  assign hit_o = (node_i.op == req_i.op) && (node_i.a0 == req_i.a0) &&
                 ((req_i.op == OP_PROP) || (node_i.a1 == req_i.a1));

endmodule

>>> rtl/formula_node_unique_table.sv
// flow: a request is scanned (S_SCAN) unless the table is empty; a hit goes to S_DONE, a miss
//   goes to S_MISS, then S_RD1 and S_RD2 to append, or straight to S_DONE with an error status
// throughput: one request at a time; the linear scan over the node store reads one
//   entry a cycle through the single store read port
// reset: asynchronous, active low; empties the table (node count to zero), no clearing pass
// store contents are undefined after reset and only entries below the count are read
`timescale 1ns / 1ps

module formula_node_unique_table #(
  parameter int unsigned MAX_NODES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  fnut_req_if.sink          req_i,
  fnut_res_if.source        res_o
);
  import fnut_pkg::*;

  localparam int unsigned IW = $clog2(MAX_NODES);       // store index width
  localparam int unsigned CW = $clog2(MAX_NODES + 1);   // count width
  localparam int unsigned EW = (CW > 8) ? CW : 8;       // operand compare width

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_MISS, S_RD1, S_RD2, S_DONE
  } state_e;

  state_e         state_q;
  req_t           req_q;
  logic [CW-1:0]  count_q;
  logic [CW-1:0]  rd_idx_q;      // next entry to read during the scan
  logic           cmp_v_q;       // read data holds entry cmp_idx_q
  logic [IW-1:0]  cmp_idx_q;
  logic           p0_q;          // flag of the first operand

  // result held until the output register is free
  logic [7:0]     res_idx_q;
  logic           res_new_q;
  logic           res_pr_q;
  logic [1:0]     res_st_q;

  // output register
  logic           out_valid_q;
  logic [7:0]     out_idx_q;
  logic           out_new_q;
  logic           out_pr_q;
  logic [1:0]     out_st_q;

  // store port and shared compare unit
  logic [IW-1:0]  ram_raddr;
  node_t          ram_rdata;
  logic           ram_we;
  node_t          ram_wdata;
  logic           hit;

  logic           last_cmp;
  logic           full;
  logic           noarg;
  logic [1:0]     ar;
  logic [EW-1:0]  cnt_ext;
  logic           pr_new;

  fnut_ram #(
    .WIDTH (NODE_W),
    .DEPTH (MAX_NODES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  fnut_match u_match (
    .node_i (ram_rdata),
    .req_i  (req_q),
    .hit_o  (hit)
  );

  // read address: scan pointer, then the two operands for the flag lookup
  always_comb begin
    unique case (state_q)
      S_MISS:  ram_raddr = IW'(req_q.a0);
      S_RD1:   ram_raddr = IW'(req_q.a1);
      default: ram_raddr = rd_idx_q[IW-1:0];
    endcase
  end

  assign last_cmp = ((CW'(cmp_idx_q) + CW'(1)) == count_q);
  assign full     = (count_q == CW'(MAX_NODES));
  assign ar       = arity(req_q.op);
  assign cnt_ext  = EW'(count_q);
  assign noarg    = ((ar != 2'd0) && (EW'(req_q.a0) >= cnt_ext)) ||
                    ((ar == 2'd2) && (EW'(req_q.a1) >= cnt_ext));

  // propositional flag; in S_RD2 the read data holds the second operand
  always_comb begin
    unique case (req_q.op)
      OP_PROP, OP_TRUE, OP_FALSE: pr_new = 1'b1;
      OP_NOT:                     pr_new = p0_q;
      OP_AND, OP_OR:              pr_new = p0_q & ram_rdata.pr;
      default:                    pr_new = 1'b0;
    endcase
  end

  assign ram_we       = (state_q == S_RD2);
  assign ram_wdata.pr = pr_new;
  assign ram_wdata.a1 = req_q.a1;
  assign ram_wdata.a0 = req_q.a0;
  assign ram_wdata.op = req_q.op;

  assign req_i.ready          = (state_q == S_IDLE);
  assign res_o.valid          = out_valid_q;
  assign res_o.node_index     = out_idx_q;
  assign res_o.was_created    = out_new_q;
  assign res_o.is_propositional = out_pr_q;
  assign res_o.status         = out_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_idx_q    <= '0;
      cmp_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // output transfer frees the register, unless a new result moves in below
      if (out_valid_q && res_o.ready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            req_q.op <= req_i.opcode;
            req_q.a0 <= req_i.first_arg;
            // prop nodes carry a zero second argument
            req_q.a1 <= (req_i.opcode == OP_PROP) ? 8'd0 : req_i.second_arg;
            rd_idx_q <= '0;
            cmp_v_q  <= 1'b0;
            state_q  <= (count_q == '0) ? S_MISS : S_SCAN;
          end
        end

        S_SCAN: begin
          // one read issued and one entry compared every cycle
          cmp_v_q   <= (rd_idx_q < count_q);
          cmp_idx_q <= rd_idx_q[IW-1:0];
          if (rd_idx_q < count_q) begin
            rd_idx_q <= rd_idx_q + CW'(1);
          end
          if (cmp_v_q && hit) begin
            res_idx_q <= 8'(cmp_idx_q);
            res_new_q <= 1'b0;
            res_pr_q  <= ram_rdata.pr;
            res_st_q  <= ST_OK;
            state_q   <= S_DONE;
          end else if (cmp_v_q && last_cmp) begin
            state_q   <= S_MISS;
          end
        end

        S_MISS: begin
          // a full table is reported before a missing operand
          if (full || noarg) begin
            res_idx_q <= 8'd0;
            res_new_q <= 1'b0;
            res_pr_q  <= 1'b0;
            res_st_q  <= full ? ST_FULL : ST_NOARG;
            state_q   <= S_DONE;
          end else begin
            state_q   <= S_RD1;
          end
        end

        S_RD1: begin
          p0_q    <= ram_rdata.pr;
          state_q <= S_RD2;
        end

        S_RD2: begin
          // append at the count
          res_idx_q <= 8'(count_q);
          res_new_q <= 1'b1;
          res_pr_q  <= pr_new;
          res_st_q  <= ST_OK;
          count_q   <= count_q + CW'(1);
          state_q   <= S_DONE;
        end

        S_DONE: begin
          // output register empty, or its transfer happens at this edge
          if (!out_valid_q || res_o.ready) begin
            out_valid_q <= 1'b1;
            out_idx_q   <= res_idx_q;
            out_new_q   <= res_new_q;
            out_pr_q    <= res_pr_q;
            out_st_q    <= res_st_q;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_NODES))
    else $error("node count beyond table size");

  a_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (count_q < CW'(MAX_NODES)))
    else $error("append into a full table");

  a_cmp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && cmp_v_q) |-> (CW'(cmp_idx_q) < count_q))
    else $error("compare of an entry beyond the count");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("ready right after a request transfer");

  a_created_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.was_created) |-> (res_o.status == ST_OK))
    else $error("created node with error status");
`endif

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import fnut_pkg::*;

  localparam int unsigned NODES        = 256;
  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RANDOM_ITEMS = 1480;
  localparam int unsigned CALM_ITEMS   = 150;      // final stretch with no idling
  localparam int unsigned LONG_HOLD    = 600;      // long result stall, in cycles
  localparam int unsigned LONG_HOLD_AT = 80;       // transfers before the long stall
  localparam int unsigned DRAIN_CYCLES = 300;      // a full scan plus margin
  localparam int unsigned CYCLE_LIMIT  = 2000000;

  // one stored node table: entries below count are valid
  typedef struct {
    node_t       slot [NODES];
    int unsigned count;
  } node_table_t;

  // what a lookup returns, one per request
  typedef struct packed {
    logic [7:0] idx;
    logic       created;
    logic       pr;
    logic [1:0] status;
  } lookup_t;

  // a formula waiting to be offered, optionally only once the block is empty
  typedef struct {
    req_t req;
    bit   drain_first;
  } stim_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // locally held copies of every driven interface signal, known from time zero
  logic req_valid = 1'b0;
  req_t req_data  = '0;
  logic res_ready = 1'b0;

  fnut_req_if req_if ();
  fnut_res_if res_if ();

  assign req_if.valid      = req_valid;
  assign req_if.opcode     = req_data.op;
  assign req_if.first_arg  = req_data.a0;
  assign req_if.second_arg = req_data.a1;
  assign res_if.ready      = res_ready;

  formula_node_unique_table #(
    .MAX_NODES(NODES)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .res_o (res_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // table as seen by the stimulus planner, and the one the checker predicts from
  node_table_t plan_table;
  node_table_t shadow_table;

  stim_t   formula_q [$];   // formulas not yet transferred
  lookup_t outcome_q [$];   // expected results, oldest first

  logic        req_taken      = 1'b0;
  bit          failed         = 1'b0;
  int unsigned taken_cnt      = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned mode_left      = 0;
  bit          burst_on       = 1'b0;
  bit          calm           = 1'b0;
  int unsigned gap_left       = 0;
  int unsigned hold_left      = 0;
  bit          long_hold_done = 1'b0;

  // hash-consing lookup: find the first equal node, else append it unless the table is full or an operand is missing
  function automatic lookup_t intern_node(inout node_table_t tbl, input req_t r);
    lookup_t     res;
    logic [7:0]  a1;
    int unsigned i;
    int unsigned n_ops;
    logic        pr;
    res = '0;
    // a proposition ignores its second argument and is stored with zero there
    a1 = (r.op == OP_PROP) ? 8'd0 : r.a1;
    for (i = 0; i < tbl.count; i++) begin
      if (tbl.slot[i].op == r.op && tbl.slot[i].a0 == r.a0 &&
          (r.op == OP_PROP || tbl.slot[i].a1 == a1)) begin
        res.idx    = i[7:0];
        res.pr     = tbl.slot[i].pr;
        res.status = ST_OK;
        return res;
      end
    end
    // a full table is reported before any operand is looked at
    if (tbl.count >= NODES) begin
      res.status = ST_FULL;
      return res;
    end
    case (r.op)
      OP_NOT, OP_NEXT:                     n_ops = 1;
      OP_AND, OP_OR, OP_UNTIL, OP_RELEASE: n_ops = 2;
      default:                             n_ops = 0;
    endcase
    if ((n_ops >= 1 && r.a0 >= tbl.count) || (n_ops == 2 && r.a1 >= tbl.count)) begin
      res.status = ST_NOARG;
      return res;
    end
    // unknown opcodes fall to the default and are never propositional
    case (r.op)
      OP_PROP, OP_TRUE, OP_FALSE: pr = 1'b1;
      OP_NOT:                     pr = tbl.slot[r.a0].pr;
      OP_AND, OP_OR:              pr = tbl.slot[r.a0].pr & tbl.slot[r.a1].pr;
      default:                    pr = 1'b0;
    endcase
    tbl.slot[tbl.count] = {pr, a1, r.a0, r.op};
    res.idx     = tbl.count[7:0];
    res.created = 1'b1;
    res.pr      = pr;
    res.status  = ST_OK;
    tbl.count++;
    return res;
  endfunction

  // random index of a node the planner knows to be stored
  function automatic logic [7:0] some_node();
    if (plan_table.count == 0) begin
      return 8'd0;
    end
    return 8'($urandom_range(0, plan_table.count - 1));
  endfunction

  task automatic add_formula(input logic [3:0] op, input logic [7:0] a0,
                             input logic [7:0] a1, input bit drain_first);
    stim_t s;
    s.req         = {op, a0, a1};
    s.drain_first = drain_first;
    void'(intern_node(plan_table, s.req));
    formula_q.push_back(s);
  endtask

  // pacing: bursty and quiet stretches, the calm tail, and the run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (mode_left == 0) begin
      burst_on  <= $urandom_range(0, 2) != 0;
      mode_left <= $urandom_range(50, 400);
    end else begin
      mode_left <= mode_left - 1;
    end
    calm <= formula_q.size() < CALM_ITEMS;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // request driver: inputs change on the falling edge
  always @(negedge clk) begin : driver
    logic offer;
    offer = 1'b0;
    if (rst_n) begin
      // the head item went across at the last rising edge
      if (req_taken) begin
        formula_q.delete(0);
      end
      if (req_valid && !req_taken) begin
        offer = 1'b1;                      // keep offering until the transfer
      end else if (gap_left != 0) begin
        gap_left--;
      end else if (formula_q.size() != 0 &&
                   !(formula_q[0].drain_first && outcome_q.size() != 0)) begin
        // now and then, while bursty and not calm, an idle gap before the next offer
        if (burst_on && !calm && $urandom_range(0, 4) == 0) begin
          gap_left = $urandom_range(0, 6);
        end else begin
          offer = 1'b1;
        end
      end
    end
    req_valid <= offer;
    if (offer) begin
      req_data <= formula_q[0].req;
    end
  end

  // result receiver: short random stalls plus one long hold-off
  always @(negedge clk) begin : receiver
    logic take;
    take = 1'b1;
    if (!rst_n) begin
      take = 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      take = 1'b0;
    end else if (!long_hold_done && taken_cnt >= LONG_HOLD_AT) begin
      // sender keeps offering meanwhile, so the block backs up onto its input
      long_hold_done = 1'b1;
      hold_left      = LONG_HOLD - 1;
      take           = 1'b0;
    end else if (burst_on && !calm && $urandom_range(0, 5) == 0) begin
      hold_left = $urandom_range(0, 6);
      take      = 1'b0;
    end
    res_ready <= take;
  end

  // monitor: predicts on each request transfer, checks each result transfer
  always @(posedge clk) begin : monitor
    lookup_t want;
    if (rst_n) begin
      req_taken <= req_if.valid && req_if.ready;
      if (req_if.valid && req_if.ready) begin
        want = intern_node(shadow_table,
                           {req_if.opcode, req_if.first_arg, req_if.second_arg});
        outcome_q.push_back(want);
        taken_cnt <= taken_cnt + 1;
      end
      if (res_if.valid && res_if.ready) begin
        if (outcome_q.size() == 0) begin
          $error("result transfer with nothing outstanding: node_index %0d status %0d",
                 res_if.node_index, res_if.status);
          failed = 1'b1;
        end else begin
          want = outcome_q.pop_front();
          if (res_if.node_index !== want.idx) begin
            $error("node_index: expected %0d, got %0d", want.idx, res_if.node_index);
            failed = 1'b1;
          end
          if (res_if.was_created !== want.created) begin
            $error("was_created: expected %0d, got %0d", want.created, res_if.was_created);
            failed = 1'b1;
          end
          if (res_if.is_propositional !== want.pr) begin
            $error("is_propositional: expected %0d, got %0d", want.pr,
                   res_if.is_propositional);
            failed = 1'b1;
          end
          if (res_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res_if.status);
            failed = 1'b1;
          end
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned k;
    int unsigned roll;
    int unsigned pick;
    logic [3:0]  op;
    logic [7:0]  a0;
    logic [7:0]  a1;

    plan_table.count   = 0;
    shadow_table.count = 0;

    // directed: every operator, argument extremes and the corner cases
    add_formula(OP_PROP,    8'd0,   8'd0,   1'b0);  // node 0
    add_formula(OP_PROP,    8'd0,   8'd255, 1'b0);  // proposition ignores second arg
    add_formula(OP_PROP,    8'd255, 8'd0,   1'b0);  // node 1
    add_formula(OP_TRUE,    8'd0,   8'd0,   1'b0);  // node 2
    add_formula(OP_FALSE,   8'd0,   8'd0,   1'b0);  // node 3
    add_formula(OP_NOT,     8'd0,   8'd0,   1'b0);  // propositional operand
    add_formula(OP_NEXT,    8'd0,   8'd0,   1'b0);  // node 5, never propositional
    add_formula(OP_AND,     8'd0,   8'd1,   1'b0);
    add_formula(OP_OR,      8'd5,   8'd0,   1'b0);  // one operand temporal
    add_formula(OP_UNTIL,   8'd0,   8'd1,   1'b0);
    add_formula(OP_RELEASE, 8'd1,   8'd0,   1'b0);
    add_formula(OP_NOT,     8'd5,   8'd0,   1'b0);  // negated temporal node
    add_formula(OP_AND,     8'd0,   8'd255, 1'b0);  // operand not yet stored
    add_formula(OP_NOT,     8'd200, 8'd0,   1'b0);
    add_formula(OP_UNTIL,   8'd255, 8'd0,   1'b0);
    add_formula(4'd15,      8'd255, 8'd255, 1'b0);  // unknown opcode, no arg check
    add_formula(4'd9,       8'd0,   8'd0,   1'b0);
    add_formula(OP_AND,     8'd0,   8'd1,   1'b0);  // repeat hits the stored node
    add_formula(OP_TRUE,    8'd170, 8'd85,  1'b0);  // constants match on both args
    add_formula(OP_NEXT,    8'd1,   8'd255, 1'b0);  // unused second arg is kept
    add_formula(OP_PROP,    8'd7,   8'd3,   1'b0);  // stored with second arg zero
    add_formula(OP_PROP,    8'd7,   8'd0,   1'b0);
    add_formula(4'd15,      8'd255, 8'd255, 1'b0);

    // random: mostly repeats and well-formed new nodes, some raw noise;
    // the table fills partway through, so full-table results follow
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 45 && plan_table.count != 0) begin
        pick = $urandom_range(0, plan_table.count - 1);
        op   = plan_table.slot[pick].op;
        a0   = plan_table.slot[pick].a0;
        a1   = (op == OP_PROP) ? 8'($urandom) : plan_table.slot[pick].a1;
      end else if (roll < 85) begin
        op = 4'($urandom_range(0, 8));
        a0 = 8'd0;
        a1 = 8'd0;
        case (op)
          OP_PROP: a0 = 8'($urandom);
          OP_NOT, OP_NEXT: a0 = some_node();
          OP_AND, OP_OR, OP_UNTIL, OP_RELEASE: begin
            a0 = some_node();
            a1 = some_node();
          end
          default: ;
        endcase
      end else begin
        {op, a0, a1} = 20'($urandom);
      end
      // twice the sender waits for every outstanding result first
      add_formula(op, a0, a1, k == 40 || k == 700);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // wait for the last transfer and its result, then let the block settle
    do begin
      @(posedge clk);
    end while (formula_q.size() != 0 || outcome_q.size() != 0 || req_valid);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (!failed) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
